FILE: rtl/bbpe_pkg.sv
// ----------------------------------------------------------------------------
// bbpe_pkg
// Shared types and constants of the box blur pixel engine: transaction
// payloads, configuration bundle, frame store request and register map.
// ----------------------------------------------------------------------------
package bbpe_pkg;

  localparam int IDX_W  = 16;  // linear pixel index
  localparam int PIX_W  = 8;   // sample width
  localparam int DIM_W  = 9;   // image width / height registers
  localparam int RAD_W  = 5;   // blur radius register
  localparam int CNT_W  = RAD_W + 1;       // window step counters, 0..2r
  localparam int ADDR_W = 2 * DIM_W;       // row * width + column < 2^18
  localparam int PADDR_W = 4;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_value;
  } bbpe_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_value;
    logic             index_error;
  } bbpe_out_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [RAD_W-1:0] blur_radius;
  } bbpe_cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } bbpe_mem_req_t;

endpackage

FILE: rtl/bbpe_div.sv
// ----------------------------------------------------------------------------
// bbpe_div
// Restoring divider, one quotient bit per cycle. Shared between the
// row/column split of a pixel index and the final window mean.
// ----------------------------------------------------------------------------
module bbpe_div #(
  parameter int DW = 19,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;

  logic [VW:0]   trial;
  logic          ge;
  logic [VW:0]   diff;

  assign trial = {rem_r, q_r[DW-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        // Dividend bits leave at the top of q_r while quotient bits enter below.
        q_r   <= {q_r[DW-2:0], ge};
        rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/bbpe_store.sv
// ----------------------------------------------------------------------------
// bbpe_store
// Frame store: one write port and one read port with registered read data.
// Addresses beyond the physical depth read as zero.
// ----------------------------------------------------------------------------
module bbpe_store
  import bbpe_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic             clk,
  input  bbpe_mem_req_t    req,
  output logic [PIX_W-1:0] rd_data
);

  // Loads never address beyond the 16-bit index space.
  localparam int FULL_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MEM_DEPTH  = (FULL_DEPTH < (1 << IDX_W)) ? FULL_DEPTH : (1 << IDX_W);
  localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [PIX_W-1:0] mem [MEM_DEPTH];
  logic [PIX_W-1:0] q_r;
  logic             hit_r;
  logic             in_mem;

  assign in_mem = 32'(req.addr) < MEM_DEPTH;

  always_ff @(posedge clk) begin
    if (req.we && in_mem) begin
      mem[req.addr[MEM_AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      q_r   <= mem[req.addr[MEM_AW-1:0]];
      hit_r <= in_mem;
    end
  end

  assign rd_data = hit_r ? q_r : '0;

endmodule

FILE: rtl/bbpe_seq.sv
// ----------------------------------------------------------------------------
// bbpe_seq
// Transaction sequencer: writes loads into the frame store, and for a query
// splits the index into row and column, walks the window one pixel per
// cycle through the store, and divides the sum by the window area.
// ----------------------------------------------------------------------------
module bbpe_seq
  import bbpe_pkg::*;
#(
  parameter int SUM_W = 19,
  parameter int DW    = 19,
  parameter int VW    = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bbpe_cfg_t        cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  bbpe_in_t         in_item,
  output bbpe_mem_req_t    mem_req,
  input  logic [PIX_W-1:0] rd_data,
  output logic             div_start,
  output logic [DW-1:0]    div_dividend,
  output logic [VW-1:0]    div_divisor,
  input  logic             div_done,
  input  logic [DW-1:0]    div_quot,
  input  logic [VW-1:0]    div_rem,
  output logic             res_valid,
  output bbpe_out_t        res,
  input  logic             res_ack
);

  localparam int POS_W  = DIM_W + 2;    // signed row / column position
  localparam int BASE_W = ADDR_W + 2;   // signed row base address

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RC,
    ST_SCAN,
    ST_DRAIN,
    ST_MEAN,
    ST_DIV_MEAN,
    ST_RESULT
  } state_t;

  state_t                   state_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [POS_W-1:0]  rr_r;
  logic signed [POS_W-1:0]  cc_r;
  logic signed [POS_W-1:0]  cc0_r;
  logic signed [BASE_W-1:0] base_r;
  logic [CNT_W-1:0]         i_r;
  logic [CNT_W-1:0]         j_r;
  logic                     rd_pend_r;
  logic [SUM_W-1:0]         sum_r;
  bbpe_out_t                res_r;

  logic                     in_fire;
  logic [ADDR_W-1:0]        limit;
  logic                     idx_in_image;
  logic [DIM_W-1:0]         row;
  logic [DIM_W-1:0]         col;
  logic [ADDR_W-1:0]        rw;
  logic [BASE_W-1:0]        row_base;
  logic signed [POS_W-1:0]  r_s;
  logic [CNT_W-1:0]         two_r;
  logic [CNT_W-1:0]         side;
  logic [2*CNT_W-1:0]       area;
  logic signed [BASE_W-1:0] scan_addr;
  logic                     in_rng;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign limit        = ADDR_W'(cfg.image_width) * ADDR_W'(cfg.image_height);
  assign idx_in_image = ADDR_W'(in_item.pixel_index) < limit;

  assign row      = div_quot[DIM_W-1:0];
  assign col      = div_rem[DIM_W-1:0];
  assign rw       = ADDR_W'(cfg.blur_radius) * ADDR_W'(cfg.image_width);
  assign row_base = BASE_W'(idx_r) - BASE_W'(col);
  assign r_s      = $signed(POS_W'(cfg.blur_radius));
  assign two_r    = {cfg.blur_radius, 1'b0};
  assign side     = two_r + 1'b1;
  assign area     = (2*CNT_W)'(side) * (2*CNT_W)'(side);

  assign scan_addr = base_r + BASE_W'(cc_r);
  assign in_rng = !rr_r[POS_W-1] && (rr_r < $signed(POS_W'(cfg.image_height))) &&
                  !cc_r[POS_W-1] && (cc_r < $signed(POS_W'(cfg.image_width)));

  always_comb begin
    mem_req.we    = in_fire && (in_item.operation == OP_LOAD) && idx_in_image;
    mem_req.re    = (state_r == ST_SCAN) && in_rng;
    mem_req.wdata = in_item.pixel_value;
    mem_req.addr  = mem_req.we ? ADDR_W'(in_item.pixel_index)
                               : scan_addr[ADDR_W-1:0];
  end

  // The divider is started from idle for the row split and from ST_MEAN
  // for the final mean; the operands follow the state.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(in_item.pixel_index);
    div_divisor  = VW'(cfg.image_width);
    if (in_fire && (in_item.operation == OP_QUERY) && idx_in_image) begin
      div_start = 1'b1;
    end else if (state_r == ST_MEAN) begin
      div_start    = 1'b1;
      div_dividend = DW'(sum_r);
      div_divisor  = VW'(area);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= mem_req.re;
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(rd_data);
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_item.operation == OP_QUERY)) begin
            idx_r <= in_item.pixel_index;
            if (idx_in_image) begin
              state_r <= ST_DIV_RC;
            end else begin
              res_r.blurred_value <= '0;
              res_r.index_error   <= 1'b1;
              state_r             <= ST_RESULT;
            end
          end
        end
        ST_DIV_RC: begin
          if (div_done) begin
            rr_r    <= $signed(POS_W'(row)) - r_s;
            cc_r    <= $signed(POS_W'(col)) - r_s;
            cc0_r   <= $signed(POS_W'(col)) - r_s;
            base_r  <= $signed(row_base) - $signed(BASE_W'(rw));
            i_r     <= '0;
            j_r     <= '0;
            sum_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (j_r == two_r) begin
            j_r    <= '0;
            cc_r   <= cc0_r;
            rr_r   <= rr_r + 1'b1;
            base_r <= base_r + $signed(BASE_W'(cfg.image_width));
            if (i_r == two_r) begin
              state_r <= ST_DRAIN;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r  <= j_r + 1'b1;
            cc_r <= cc_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The last window read lands in the sum at this edge.
          state_r <= ST_MEAN;
        end
        ST_MEAN: begin
          state_r <= ST_DIV_MEAN;
        end
        ST_DIV_MEAN: begin
          if (div_done) begin
            res_r.blurred_value <= div_quot[PIX_W-1:0];
            res_r.index_error   <= 1'b0;
            state_r             <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (res_ack) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state_r == ST_RESULT);
  assign res       = res_r;

endmodule

FILE: rtl/box_blur_pixel_engine_core.sv
// ----------------------------------------------------------------------------
// box_blur_pixel_engine_core
// Zero-padded box blur over one 8-bit image channel held in a frame store.
//
//   channel   direction  handshake            payload
//   in_       in         in_valid / in_ready  bbpe_in_t  (operation, index, value)
//   out_      out        out_valid/out_ready  bbpe_out_t (blurred value, index error)
//   config    in/out     APB psel/penable     width, height, radius registers
//
// A load writes the frame store directly.
// A query reads the window from the frame store at one pixel per cycle, and
// the shared bit-serial divider runs twice, once for the row/column split and
// once for the mean.
// The result sits in an output register, so loads are taken while it waits.
// Reset is synchronous; the frame store has no clearing pass and holds
// garbage until written.
// ----------------------------------------------------------------------------
module box_blur_pixel_engine_core
  import bbpe_pkg::*;
#(
  parameter int MAX_DIM    = 256,
  parameter int MAX_RADIUS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbpe_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bbpe_out_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);
  localparam int AREA_W   = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int DW       = (SUM_W > IDX_W) ? SUM_W : IDX_W;
  localparam int VW       = (AREA_W > DIM_W) ? AREA_W : DIM_W;
  localparam int DIM_RST  = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam int RAD_RST  = (MAX_RADIUS < 4) ? MAX_RADIUS : 4;

  bbpe_cfg_t        cfg_r;
  logic             out_valid_r;
  bbpe_out_t        out_data_r;

  logic             wr;
  logic [1:0]       reg_sel;
  logic [DIM_W-1:0] dim_v;
  logic [DIM_W-1:0] dim_sat;
  logic [RAD_W-1:0] rad_v;
  logic [RAD_W-1:0] rad_sat;

  bbpe_mem_req_t    mem_req;
  logic [PIX_W-1:0] rd_data;
  logic             div_start;
  logic [DW-1:0]    div_dividend;
  logic [VW-1:0]    div_divisor;
  logic             div_done;
  logic [DW-1:0]    div_quot;
  logic [VW-1:0]    div_rem;
  logic             res_valid;
  bbpe_out_t        res;
  logic             res_ack;

  // Configuration port
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  assign dim_v = pwdata[DIM_W-1:0];
  assign rad_v = pwdata[RAD_W-1:0];

  always_comb begin
    if (dim_v == '0) begin
      dim_sat = DIM_W'(1);
    end else if (32'(dim_v) > MAX_DIM) begin
      dim_sat = DIM_W'(MAX_DIM);
    end else begin
      dim_sat = dim_v;
    end
    if (32'(rad_v) > MAX_RADIUS) begin
      rad_sat = RAD_W'(MAX_RADIUS);
    end else begin
      rad_sat = rad_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= DIM_W'(DIM_RST);
      cfg_r.image_height <= DIM_W'(DIM_RST);
      cfg_r.blur_radius  <= RAD_W'(RAD_RST);
    end else if (wr) begin
      case (reg_sel)
        REG_WIDTH:  cfg_r.image_width  <= dim_sat;
        REG_HEIGHT: cfg_r.image_height <= dim_sat;
        REG_RADIUS: cfg_r.blur_radius  <= rad_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = 32'(cfg_r.image_width);
      REG_HEIGHT: prdata = 32'(cfg_r.image_height);
      REG_RADIUS: prdata = 32'(cfg_r.blur_radius);
      default:    prdata = '0;
    endcase
  end

  bbpe_seq #(
    .SUM_W (SUM_W),
    .DW    (DW),
    .VW    (VW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_data),
    .mem_req      (mem_req),
    .rd_data      (rd_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_rem      (div_rem),
    .res_valid    (res_valid),
    .res          (res),
    .res_ack      (res_ack)
  );

  bbpe_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bbpe_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Output register
  assign res_ack = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/bbpe_checker.sv
// ----------------------------------------------------------------------------
// bbpe_checker
// Port-level checks of the box blur pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
module bbpe_checker
  import bbpe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input bbpe_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input bbpe_out_t out_data
);

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // An out-of-range query reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.blurred_value == '0)
    else $error("index error with nonzero value");

  // A query occupies the engine: no transaction is taken in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == OP_QUERY) |=> !in_ready)
    else $error("input accepted right after a query");

endmodule

bind box_blur_pixel_engine_core bbpe_checker u_bbpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/box_blur_pixel_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_pixel_engine_core_tb
// Self-checking bench for the box blur engine. Loads and queries are driven
// over the valid/ready input with random gaps. A scoreboard keeps its own frame
// store and geometry and predicts each query's window mean and range flag.
// Results are taken with random stalls and one long hold-off that backs up the
// input. Before any query, every window pixel inside the image has been loaded.
// ----------------------------------------------------------------------------
module box_blur_pixel_engine_core_tb;
  import bbpe_pkg::*;

  localparam int MAX_DIM        = 256;
  localparam int MAX_RADIUS     = 20;
  localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ITEM_TARGET    = 350;
  localparam int HOLD_CYCLES    = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  // Address slot past the register list; writes there must be ignored.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  class blur_scoreboard;
    logic [PIX_W-1:0] frame [STORE_DEPTH];
    int img_width;
    int img_height;
    int radius;
    bbpe_out_t blur_expected_q[$];
    int errors;

    function new();
      img_width  = MAX_DIM;
      img_height = MAX_DIM;
      radius     = 4;
      errors     = 0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    function int clamp_dim(logic [DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
    endfunction

    function void write_register(logic [1:0] reg_idx, logic [31:0] value);
      case (reg_idx)
        REG_WIDTH:  img_width  = clamp_dim(value[DIM_W-1:0]);
        REG_HEIGHT: img_height = clamp_dim(value[DIM_W-1:0]);
        REG_RADIUS: begin
          if (value[RAD_W-1:0] > MAX_RADIUS) radius = MAX_RADIUS;
          else radius = int'(value[RAD_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    // Pixels outside the image count as zero, but the divisor is always the
    // full window area.
    function logic [PIX_W-1:0] window_mean(int idx);
      int row;
      int col;
      int rr;
      int cc;
      int unsigned sum;
      int unsigned side;
      row  = idx / img_width;
      col  = idx % img_width;
      sum  = 0;
      side = 2 * radius + 1;
      for (rr = row - radius; rr <= row + radius; rr++) begin
        if (rr < 0 || rr >= img_height) continue;
        for (cc = col - radius; cc <= col + radius; cc++) begin
          if (cc < 0 || cc >= img_width) continue;
          sum += frame[rr * img_width + cc];
        end
      end
      return PIX_W'(sum / (side * side));
    endfunction

    function void take_item(bbpe_in_t item);
      bbpe_out_t want;
      int idx;
      bit in_img;
      idx    = int'(item.pixel_index);
      in_img = idx < img_width * img_height;
      if (item.operation == OP_LOAD) begin
        if (in_img) frame[idx] = item.pixel_value;
      end else begin
        want.index_error   = !in_img;
        want.blurred_value = in_img ? window_mean(idx) : '0;
        blur_expected_q.push_back(want);
      end
    endfunction

    function void check_result(bbpe_out_t got);
      bbpe_out_t want;
      if (blur_expected_q.size() == 0) begin
        $display("%0t: blur result with no query waiting: value %0d error %0b",
                 $time, got.blurred_value, got.index_error);
        errors++;
        return;
      end
      want = blur_expected_q.pop_front();
      if (got.blurred_value !== want.blurred_value) begin
        $display("%0t: blurred_value mismatch: expected %0d actual %0d",
                 $time, want.blurred_value, got.blurred_value);
        errors++;
      end
      if (got.index_error !== want.index_error) begin
        $display("%0t: index_error mismatch: expected %0b actual %0b",
                 $time, want.index_error, got.index_error);
        errors++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  bbpe_in_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bbpe_out_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  blur_scoreboard sb;
  bit loaded [STORE_DEPTH];
  int counted_items = 0;
  bit no_gaps       = 1'b0;
  bit pressure_go   = 1'b0;
  int idle_cycles   = 0;

  box_blur_pixel_engine_core #(
    .MAX_DIM    (MAX_DIM),
    .MAX_RADIUS (MAX_RADIUS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("box_blur_pixel_engine_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: short and long stalls, stretches of steady acceptance, and
  // one long hold-off once the stimulus asks for it.
  initial begin : result_sink
    int stall;
    int steady;
    int roll;
    bit pressure_served;
    stall = 0;
    steady = 0;
    pressure_served = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go && !pressure_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_served = 1'b1;
      end else if (steady > 0) begin
        steady--;
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2) steady = $urandom_range(100, 400);
        else if (roll < 6) stall = $urandom_range(20, 80);
        else if (roll < 36) stall = $urandom_range(1, 4);
        out_ready <= (stall == 0);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit in_image(int idx);
    return idx < sb.img_width * sb.img_height;
  endfunction

  // Called and returns at a falling edge; valid is left high for the next call.
  task automatic send_item(logic op, int idx, int val);
    bbpe_in_t item;
    int gap;
    item.operation   = op;
    item.pixel_index = IDX_W'(idx);
    item.pixel_value = PIX_W'(val);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.take_item(item);
    if (op == OP_QUERY || in_image(idx)) counted_items++;
    if (op == OP_LOAD && in_image(idx)) loaded[idx] = 1'b1;
    @(negedge clk);
  endtask

  // Loads every in-image pixel of the window that has never been written.
  task automatic load_window(int idx, int fill);
    int row;
    int col;
    int rr;
    int cc;
    int a;
    row = idx / sb.img_width;
    col = idx % sb.img_width;
    for (rr = row - sb.radius; rr <= row + sb.radius; rr++) begin
      if (rr < 0 || rr >= sb.img_height) continue;
      for (cc = col - sb.radius; cc <= col + sb.radius; cc++) begin
        if (cc < 0 || cc >= sb.img_width) continue;
        a = rr * sb.img_width + cc;
        if (!loaded[a]) send_item(OP_LOAD, a, (fill < 0) ? $urandom_range(0, 255) : fill);
      end
    end
  endtask

  task automatic query_pixel(int idx, int fill);
    if (in_image(idx)) load_window(idx, fill);
    send_item(OP_QUERY, idx, $urandom_range(0, 255));
  endtask

  task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(reg_idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drops valid, waits for every query to come back, then lets a trailing
  // load finish before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.blur_expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register word for a dimension, sometimes out of range or with junk above
  // the field so that saturation and masking are exercised.
  function automatic logic [31:0] dim_word(int d);
    logic [31:0] word;
    word = ($urandom_range(0, 4) == 0) ? $urandom : 32'd0;
    if (d == MAX_DIM && $urandom_range(0, 2) == 0)
      word[DIM_W-1:0] = DIM_W'($urandom_range(MAX_DIM + 1, 511));
    else if (d == 1 && $urandom_range(0, 2) == 0)
      word[DIM_W-1:0] = '0;
    else
      word[DIM_W-1:0] = DIM_W'(d);
    return word;
  endfunction

  function automatic logic [31:0] radius_word(int rad);
    logic [31:0] word;
    word = ($urandom_range(0, 4) == 0) ? $urandom : 32'd0;
    if (rad == MAX_RADIUS && $urandom_range(0, 1) == 0)
      word[RAD_W-1:0] = RAD_W'($urandom_range(MAX_RADIUS + 1, 31));
    else
      word[RAD_W-1:0] = RAD_W'(rad);
    return word;
  endfunction

  // Large images get small radii so that preloading a window stays cheap.
  task automatic pick_geometry();
    int roll;
    int w;
    int h;
    int rad;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 10);
      rad = $urandom_range(0, MAX_RADIUS);
    end else if (roll < 65) begin
      w = MAX_DIM;
      h = $urandom_range(1, 2);
      rad = $urandom_range(0, MAX_RADIUS);
    end else if (roll < 75) begin
      w = $urandom_range(1, 2);
      h = MAX_DIM;
      rad = $urandom_range(0, MAX_RADIUS);
    end else begin
      w = ($urandom_range(0, 3) == 0) ? MAX_DIM : $urandom_range(1, MAX_DIM);
      h = ($urandom_range(0, 3) == 0) ? MAX_DIM : $urandom_range(1, MAX_DIM);
      rad = $urandom_range(0, 1);
    end
    write_reg(REG_WIDTH, dim_word(w));
    write_reg(REG_HEIGHT, dim_word(h));
    write_reg(REG_RADIUS, radius_word(rad));
    if ($urandom_range(0, 5) == 0) write_reg(REG_UNMAPPED, $urandom);
  endtask

  task automatic random_item(bit queries_only);
    int lim;
    int roll;
    lim  = sb.img_width * sb.img_height;
    roll = $urandom_range(0, 99);
    if (queries_only || roll < 55) begin
      if (lim < STORE_DEPTH && $urandom_range(0, 99) < 15)
        query_pixel($urandom_range(lim, STORE_DEPTH - 1), -1);
      else
        query_pixel($urandom_range(0, lim - 1), -1);
    end else if (roll < 92 || lim >= STORE_DEPTH) begin
      send_item(OP_LOAD, $urandom_range(0, lim - 1), $urandom_range(0, 255));
    end else begin
      send_item(OP_LOAD, $urandom_range(lim, STORE_DEPTH - 1), $urandom_range(0, 255));
    end
  endtask

  initial begin : stimulus
    int phase;
    int n;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry with a single-pixel window: extreme index and value.
    write_reg(REG_RADIUS, 32'd0);
    send_item(OP_LOAD, STORE_DEPTH - 1, 255);
    send_item(OP_QUERY, STORE_DEPTH - 1, 0);
    send_item(OP_LOAD, 0, 0);
    send_item(OP_QUERY, 0, 255);
    send_item(OP_LOAD, MAX_DIM, 8'h5A);
    query_pixel(MAX_DIM, -1);
    settle();

    // Zero dimensions saturate to a 1x1 image and the radius to its maximum.
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'hFFFF_FE00);
    write_reg(REG_RADIUS, 32'd31);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 0, 255);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_QUERY, 1, 0);
    send_item(OP_LOAD, 1, 77);
    send_item(OP_QUERY, STORE_DEPTH - 1, 0);
    settle();

    // Oversized width saturates to the full row; corners of a two-row image.
    write_reg(REG_WIDTH, 32'd511);
    write_reg(REG_HEIGHT, 32'd2);
    write_reg(REG_RADIUS, 32'd1);
    query_pixel(0, 255);
    query_pixel(2 * MAX_DIM - 1, 0);
    send_item(OP_QUERY, 2 * MAX_DIM, 0);
    send_item(OP_LOAD, 2 * MAX_DIM, 1);
    settle();

    phase = 0;
    while (counted_items < ITEM_TARGET) begin
      settle();
      pick_geometry();
      no_gaps = ($urandom_range(0, 3) == 0);
      // The first random phase picks only queries, with their window preloads, while results are held off.
      if (phase == 0) pressure_go = 1'b1;
      n = $urandom_range(15, 35);
      repeat (n) begin
        if (counted_items < ITEM_TARGET) random_item(phase == 0);
      end
      phase++;
    end
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.errors == 0 && sb.blur_expected_q.size() == 0)
      $display("box_blur_pixel_engine_core regression: pass");
    else
      $display("box_blur_pixel_engine_core regression: fail");
    $finish;
  end

endmodule
